// File: design/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg: shared types and constants for the scroll run side margin block
// Map size, register codes, field widths, controller states, read selects
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srm_pkg;

  // Scroll map depth and its address width
  localparam int MAP_DEPTH = 256;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Configuration port widths and register codes
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] REG_ROOM_COLUMNS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ROOM_ROWS    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MARGIN_LIMIT = 2'd2;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MID_RD,
    ST_MID_CK,
    ST_LC_RD,
    ST_LC_CK,
    ST_RC_RD,
    ST_RC_CK,
    ST_LEFT_RD,
    ST_LEFT_CK,
    ST_RIGHT_RD,
    ST_RIGHT_CK,
    ST_DONE
  } state_t;

  // Column the map read looks at
  typedef enum logic [2:0] {
    RD_MID,
    RD_LC,
    RD_RC,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    write;       // store a map entry from the accepted word
    logic    latch;       // capture camera position of the accepted word
    logic    prep;        // clamp midpoint, compute row base and edge columns
    rd_sel_t rd_sel;      // column to read or take
    logic    take;        // start the run at the selected column
    logic    step_left;   // extend run one screen left
    logic    step_right;  // extend run one screen right
    logic    set_zero;    // result is all zeros
    logic    load_out;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enable;      // room and limit allow margins
    logic lc_ok;       // left edge column lies in the room
    logic rc_ok;       // right edge column lies in the room
    logic open;        // screen read last cycle is open
    logic first_zero;  // run reaches column zero
    logic last_end;    // run reaches the last column
    logic out_free;    // result register can take a word
  } sts_t;

endpackage

// File: design/srm_item_if.sv
// ----------------------------------------------------------------------------
// srm_item_if: input word channel
// Valid/ready channel carrying one map write or one margin query.
// ----------------------------------------------------------------------------
interface srm_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [7:0]         map_index;
  logic [7:0]         map_value;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;

  modport source (output valid, mode, map_index, map_value, view_x, view_y,
                  input ready);
  modport sink   (input valid, mode, map_index, map_value, view_x, view_y,
                  output ready);
endinterface

// File: design/srm_result_if.sv
// ----------------------------------------------------------------------------
// srm_result_if: result word channel
// Valid/ready channel carrying the left and right spare pixel counts.
// ----------------------------------------------------------------------------
interface srm_result_if;
  logic       valid;
  logic       ready;
  logic [8:0] left_spare;
  logic [8:0] right_spare;

  modport source (output valid, left_spare, right_spare, input ready);
  modport sink   (input valid, left_spare, right_spare, output ready);
endinterface

// File: design/srm_cfg_if.sv
// ----------------------------------------------------------------------------
// srm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface srm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [srm_pkg::CFG_IW-1:0] index;
  logic [srm_pkg::CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/srm_ctrl.sv
// ----------------------------------------------------------------------------
// srm_ctrl: query sequencer
// Walks a query through midpoint, edge fallbacks, run extension and result
// hand-off, one map read per probe.
// ----------------------------------------------------------------------------
module srm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          query,
  output logic          ready,
  output srm_pkg::cmd_t cmd,
  input  srm_pkg::sts_t sts
);
  import srm_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && query) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = sts.enable ? ST_MID_RD : ST_DONE;
      end
      ST_MID_RD: state_next = ST_MID_CK;
      ST_MID_CK: begin
        if (sts.open)       state_next = ST_LEFT_RD;
        else if (sts.lc_ok) state_next = ST_LC_RD;
        else if (sts.rc_ok) state_next = ST_RC_RD;
        else                state_next = ST_DONE;
      end
      ST_LC_RD: state_next = ST_LC_CK;
      ST_LC_CK: begin
        if (sts.open)       state_next = ST_LEFT_RD;
        else if (sts.rc_ok) state_next = ST_RC_RD;
        else                state_next = ST_DONE;
      end
      ST_RC_RD: state_next = ST_RC_CK;
      ST_RC_CK: begin
        state_next = sts.open ? ST_LEFT_RD : ST_DONE;
      end
      ST_LEFT_RD: begin
        state_next = sts.first_zero ? ST_RIGHT_RD : ST_LEFT_CK;
      end
      ST_LEFT_CK: begin
        state_next = sts.open ? ST_LEFT_RD : ST_RIGHT_RD;
      end
      ST_RIGHT_RD: begin
        state_next = sts.last_end ? ST_DONE : ST_RIGHT_CK;
      end
      ST_RIGHT_CK: begin
        state_next = sts.open ? ST_RIGHT_RD : ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ready = 1'b0;
    cmd   = '0;
    cmd.rd_sel = RD_MID;
    unique case (state)
      ST_IDLE: begin
        ready     = 1'b1;
        cmd.write = accept && !query;
        cmd.latch = accept && query;
      end
      ST_PREP: begin
        cmd.prep     = 1'b1;
        cmd.set_zero = !sts.enable;
      end
      ST_MID_RD: cmd.rd_sel = RD_MID;
      ST_MID_CK: begin
        cmd.rd_sel   = RD_MID;
        cmd.take     = sts.open;
        cmd.set_zero = !sts.open && !sts.lc_ok && !sts.rc_ok;
      end
      ST_LC_RD: cmd.rd_sel = RD_LC;
      ST_LC_CK: begin
        cmd.rd_sel   = RD_LC;
        cmd.take     = sts.open;
        cmd.set_zero = !sts.open && !sts.rc_ok;
      end
      ST_RC_RD: cmd.rd_sel = RD_RC;
      ST_RC_CK: begin
        cmd.rd_sel   = RD_RC;
        cmd.take     = sts.open;
        cmd.set_zero = !sts.open;
      end
      ST_LEFT_RD: cmd.rd_sel = RD_LEFT;
      ST_LEFT_CK: begin
        cmd.rd_sel    = RD_LEFT;
        cmd.step_left = sts.open;
      end
      ST_RIGHT_RD: cmd.rd_sel = RD_RIGHT;
      ST_RIGHT_CK: begin
        cmd.rd_sel     = RD_RIGHT;
        cmd.step_right = sts.open;
      end
      ST_DONE: cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

// File: design/srm_dpath.sv
// ----------------------------------------------------------------------------
// srm_dpath: map storage and margin arithmetic
// Holds the registers, the open/locked map with per-entry valid bits, the
// query scratch registers and the result register.
// ----------------------------------------------------------------------------
module srm_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [srm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [srm_pkg::CFG_DW-1:0] cfg_data,
  input  logic [7:0]                 map_index,
  input  logic [7:0]                 map_value,
  input  logic signed [15:0]         view_x,
  input  logic signed [15:0]         view_y,
  input  srm_pkg::cmd_t              cmd,
  output srm_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [8:0]                 left_spare,
  output logic [8:0]                 right_spare
);
  import srm_pkg::*;

  function automatic logic [8:0] clamp_spare(input logic [17:0] v, input logic [8:0] lim);
    logic [8:0] r;
    if (v[17]) begin
      r = '0;
    end else if (v > {9'd0, lim}) begin
      r = lim;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  logic [7:0]          cols, rows;
  logic [8:0]          limit;
  logic                map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] map_vld;
  logic                rd_bit, rd_vld;
  logic [15:0]         wr_ext;
  logic                wr_ok;
  logic [MAP_AW-1:0]   wr_addr, rd_addr;
  logic [15:0]         addr_sum;
  logic signed [15:0]  cx, cy;
  logic [MAP_AW-1:0]   base;
  logic [7:0]          mid, lc, rc, first, last, col_pick;
  logic                lc_ok, rc_ok, zero_res;
  logic signed [16:0]  sum_y, sum_x, sum_rc;
  logic [8:0]          row_f, col_f;
  logic [7:0]          row_c, col_c;
  logic [15:0]         base_prod, area;
  logic [17:0]         left_raw, right_raw;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cols  <= '0;
      rows  <= '0;
      limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROOM_COLUMNS: cols  <= cfg_data[7:0];
        REG_ROOM_ROWS:    rows  <= cfg_data[7:0];
        REG_MARGIN_LIMIT: limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Map write address, dropped beyond the map
  assign wr_ext  = {8'd0, map_index};
  assign wr_ok   = wr_ext < 16'(MAP_DEPTH);
  assign wr_addr = wr_ext[MAP_AW-1:0];

  // Map storage and registered read
  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      map_mem[wr_addr] <= (map_value != 8'd0);
    end
    rd_bit <= map_mem[rd_addr];
    rd_vld <= map_vld[rd_addr];
  end

  // Entry valid bits: an entry never written reads as locked
  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
    end else if (cmd.write && wr_ok) begin
      map_vld[wr_addr] <= 1'b1;
    end
  end

  // Midpoint and edge column arithmetic
  always_comb begin
    sum_y = 17'(cy) + 17'sd128;
    sum_x = 17'(cx) + 17'sd128;
    sum_rc = 17'(cx) + 17'sd255;
    row_f = sum_y[16:8];
    col_f = sum_x[16:8];
    if (row_f[8]) begin
      row_c = '0;
    end else if (row_f[7:0] >= rows) begin
      row_c = rows - 8'd1;
    end else begin
      row_c = row_f[7:0];
    end
    if (col_f[8]) begin
      col_c = '0;
    end else if (col_f[7:0] >= cols) begin
      col_c = cols - 8'd1;
    end else begin
      col_c = col_f[7:0];
    end
    base_prod = 16'(row_c) * 16'(cols);
  end

  // Room check
  assign area = 16'(cols) * 16'(rows);
  assign sts.enable = (limit != 9'd0) && (cols != 8'd0) && (rows != 8'd0)
                      && (area <= 16'(MAP_DEPTH));

  // Capture camera position
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cx <= view_x;
      cy <= view_y;
    end
  end

  // Query scratch registers
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      base  <= base_prod[MAP_AW-1:0];
      mid   <= col_c;
      lc    <= cx[15:8];
      rc    <= sum_rc[15:8];
      lc_ok <= !cx[15] && (cx[15:8] < cols);
      rc_ok <= !sum_rc[16] && (sum_rc[15:8] < cols);
    end
    if (cmd.take) begin
      first <= col_pick;
      last  <= col_pick;
    end else begin
      if (cmd.step_left)  first <= first - 8'd1;
      if (cmd.step_right) last  <= last + 8'd1;
    end
  end

  // Zero-result flag; a disabled room sets it in the setup cycle itself
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_res <= 1'b0;
    end else if (cmd.set_zero) begin
      zero_res <= 1'b1;
    end else if (cmd.prep) begin
      zero_res <= 1'b0;
    end
  end

  // Pick the probed column and form the map address
  always_comb begin
    unique case (cmd.rd_sel)
      RD_MID:   col_pick = mid;
      RD_LC:    col_pick = lc;
      RD_RC:    col_pick = rc;
      RD_LEFT:  col_pick = first - 8'd1;
      RD_RIGHT: col_pick = last + 8'd1;
      default:  col_pick = mid;
    endcase
    addr_sum = 16'(base) + {8'd0, col_pick};
    rd_addr  = addr_sum[MAP_AW-1:0];
  end

  // Status
  assign sts.lc_ok      = lc_ok;
  assign sts.rc_ok      = rc_ok;
  assign sts.open       = rd_bit && rd_vld;
  assign sts.first_zero = (first == 8'd0);
  assign sts.last_end   = ({1'b0, last} + 9'd1) >= {1'b0, cols};
  assign sts.out_free   = !out_valid || out_ready;

  // Spare pixels on each side of the viewport
  assign left_raw  = 18'(cx) - {2'b00, first, 8'd0};
  assign right_raw = {2'b00, last, 8'd0} - 18'(cx);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_spare  <= zero_res ? 9'd0 : clamp_spare(left_raw, limit);
      right_spare <= zero_res ? 9'd0 : clamp_spare(right_raw, limit);
    end
  end

endmodule

// File: design/scroll_run_side_margins.sv
// ----------------------------------------------------------------------------
// scroll_run_side_margins: spare pixels of the open scroll run
// Keeps an open/locked map of 256-pixel screens and, per query, reports
// how far the run of open screens reaches beyond each side of the view.
// ----------------------------------------------------------------------------
// Channels: item (map write or query), result (left_spare, right_spare),
// cfg (register writes: room_columns, room_rows, margin_limit; always ready).
// A map write (mode 0) returns no word; item is ready again in the next
// cycle. A query (mode 1) returns one word.
// Query steps: accept, a setup step, then for each screen probed one map
// read and one check, then the load of the result register, which waits
// until the result register is free. Probes cover the midpoint and edge
// columns, then the screens walked left and right. The single map read
// port has a registered output.
// One query is in flight at a time; item stays low until its result is in
// the result register. The next item is taken while that word waits, so a
// stalled receiver blocks only the following query's hand-off.
// Reset clears the registers and marks every map screen locked; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module scroll_run_side_margins (
  input logic           clk,
  input logic           rst,
  srm_cfg_if.sink       cfg,
  srm_item_if.sink      item,
  srm_result_if.source  result
);
  import srm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_rdy;
  logic accept;

  // Handshakes
  assign cfg.ready  = 1'b1;
  assign item.ready = in_rdy;
  assign accept     = item.valid && in_rdy;

  srm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .query  (item.mode == MODE_QUERY),
    .ready  (in_rdy),
    .cmd    (cmd),
    .sts    (sts)
  );

  srm_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .map_index   (item.map_index),
    .map_value   (item.map_value),
    .view_x      (item.view_x),
    .view_y      (item.view_y),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .left_spare  (result.left_spare),
    .right_spare (result.right_spare)
  );

endmodule

// File: design/srm_checker.sv
// ----------------------------------------------------------------------------
// srm_checker: port-level checks for the scroll run side margin block
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module srm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] left_spare,
  input logic [8:0] right_spare
);
  import srm_pkg::*;

  // Result register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_spare) && $stable(right_spare))
    else $error("stalled result word changed");

  // A query blocks the item channel until its result is loaded
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == MODE_QUERY |=> !in_ready)
    else $error("item taken during a query");

  // A map write leaves the item channel ready
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == MODE_WRITE |=> in_ready)
    else $error("map write stalled the item channel");

  // A new result only appears at the end of a query
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a query");

endmodule

bind scroll_run_side_margins srm_checker u_srm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .in_mode     (item.mode),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .left_spare  (result.left_spare),
  .right_spare (result.right_spare)
);
